@@ src/bkls_pkg.sv @@
package bkls_pkg;

  // width of the boundary_count register
  localparam int BcWidth = 9;
  localparam int CfgDataWidth = 32;
  localparam int FoundWidth = 33;
  localparam int StatusWidth = 3;

  // configuration register indexes
  localparam logic CFG_BOUNDARY_COUNT = 1'b0;
  localparam logic CFG_INDEX_OFFSET   = 1'b1;

  // command field codes
  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // result status codes
  localparam logic [StatusWidth-1:0] ST_OK         = 3'd0;
  localparam logic [StatusWidth-1:0] ST_TABLE_FULL = 3'd1;
  localparam logic [StatusWidth-1:0] ST_STORE_FULL = 3'd2;
  localparam logic [StatusWidth-1:0] ST_INCOMPLETE = 3'd3;
  localparam logic [StatusWidth-1:0] ST_TOO_LONG   = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_KEY,
    S_FETCH,
    S_CMP
  } bkls_state_e;

  // controller to datapath
  typedef struct packed {
    logic take;         // input word accepted this cycle
    logic load_key;     // latch start and length of probed key
    logic next_byte;    // advance compare position
    logic update_len;   // narrow range on length compare
    logic update_byte;  // narrow range on byte compare
    logic finish;       // search done, emit index
  } bkls_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic search_go;
    logic lo_lt_hi;
    logic bytes_left;
    logic byte_diff;
  } bkls_stat_t;

endpackage

@@ src/bkls_ram.sv @@
module bkls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/bkls_ctrl.sv @@
module bkls_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  bkls_pkg::bkls_stat_t stat_i,
  output bkls_pkg::bkls_cmd_t  cmd_o,
  output logic              busy_o
);

  import bkls_pkg::*;

  bkls_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.take = 1'b1;
          if (stat_i.search_go) begin
            state_d = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        // key table read at midpoint is in flight when range still open
        if (stat_i.lo_lt_hi) begin
          state_d = S_KEY;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_KEY: begin
        cmd_o.load_key = 1'b1;
        state_d        = S_FETCH;
      end
      S_FETCH: begin
        if (stat_i.bytes_left) begin
          state_d = S_CMP;
        end else begin
          cmd_o.update_len = 1'b1;
          state_d          = S_PROBE;
        end
      end
      S_CMP: begin
        if (stat_i.byte_diff) begin
          cmd_o.update_byte = 1'b1;
          state_d           = S_PROBE;
        end else begin
          cmd_o.next_byte = 1'b1;
          state_d         = S_FETCH;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

@@ src/bkls_dp.sv @@
module bkls_dp #(
  parameter int MAX_KEYS = 256,
  parameter int KEY_STORE_BYTES = 4096,
  parameter int MAX_KEY_LEN = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bkls_pkg::bkls_cmd_t              cmd_i,
  output bkls_pkg::bkls_stat_t             stat_o,
  input  logic                             cmd_field_i,
  input  logic [7:0]                       key_byte_i,
  input  logic                             last_byte_i,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [bkls_pkg::CfgDataWidth-1:0] cfg_wdata_i,
  output logic                             done_o,
  output logic [bkls_pkg::FoundWidth-1:0]  found_index_o,
  output logic [bkls_pkg::StatusWidth-1:0] status_o
);

  import bkls_pkg::*;

  localparam int IW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int AW = $clog2(KEY_STORE_BYTES);
  localparam int BW = $clog2(KEY_STORE_BYTES + 1);
  localparam int LW = $clog2(MAX_KEY_LEN + 1);
  localparam int QW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
  localparam int EW = (CW > BcWidth) ? CW : BcWidth;
  localparam int PW = $clog2(KEY_STORE_BYTES + MAX_KEY_LEN + 1);
  localparam int SW = ((BW > LW) ? BW : LW) + 1;
  localparam int RW = ((AW > LW) ? AW : LW) + 1;
  localparam int TW = AW + LW;

  // configuration
  logic [BcWidth-1:0]      bc_q;
  logic [CfgDataWidth-1:0] off_q;

  // table and key assembly state
  logic [LW-1:0] cur_len_q;
  logic          ovf_q;
  logic [CW-1:0] keys_q;
  logic [BW-1:0] used_q;

  // search state
  logic [IW-1:0] lo_q, hi_q;
  logic [LW-1:0] qlen_q, klen_q, n_q, i_q;
  logic [AW-1:0] start_q;

  // output
  logic                   valid_q, valid_d;
  logic [FoundWidth-1:0]  found_q, found_d;
  logic [StatusWidth-1:0] status_q, status_d;

  logic          pos_full, ovf_now, is_last, search_go, add_ok;
  logic          tab_full, store_full, table_ok, below;
  logic [LW-1:0] len_now;
  logic [PW-1:0] wr_pos;
  logic [EW-1:0] bc_ext, eff, keys_ext, eff_m1;
  logic [IW:0]   mid_sum;
  logic [IW-1:0] mid;
  logic          ks_we, qb_we;
  logic [RW-1:0] ks_rsum;
  logic [TW-1:0] kt_rdata;
  logic [AW-1:0] rd_start;
  logic [LW-1:0] rd_len;
  logic [7:0]    ks_rdata, qb_rdata;

  assign pos_full = cur_len_q >= LW'(MAX_KEY_LEN);
  assign len_now  = pos_full ? cur_len_q : cur_len_q + 1'b1;
  assign ovf_now  = ovf_q | pos_full;
  assign wr_pos   = PW'(used_q) + PW'(cur_len_q);

  assign bc_ext   = EW'(bc_q);
  assign eff      = (bc_ext > EW'(MAX_KEYS)) ? EW'(MAX_KEYS) : bc_ext;
  assign eff_m1   = eff - 1'b1;
  assign keys_ext = EW'(keys_q);

  assign tab_full   = keys_ext >= eff;
  assign store_full = (SW'(used_q) + SW'(len_now)) > SW'(KEY_STORE_BYTES);
  assign table_ok   = (eff != '0) && (keys_ext == eff);

  assign is_last   = cmd_i.take & last_byte_i;
  assign search_go = is_last & (cmd_field_i == CMD_SEARCH) & ~ovf_now & table_ok;
  assign add_ok    = is_last & (cmd_field_i == CMD_ADD) & ~ovf_now & ~tab_full & ~store_full;

  assign ks_we = cmd_i.take & ~pos_full & (cmd_field_i == CMD_ADD)
               & (wr_pos < PW'(KEY_STORE_BYTES));
  assign qb_we = cmd_i.take & ~pos_full & (cmd_field_i == CMD_SEARCH);

  // upper-rounded midpoint
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} + 1'b1;
  assign mid     = mid_sum[IW:1];

  assign ks_rsum  = RW'(start_q) + RW'(i_q);
  assign rd_start = kt_rdata[TW-1:LW];
  assign rd_len   = kt_rdata[LW-1:0];

  assign below = cmd_i.update_len ? (qlen_q < klen_q) : (qb_rdata < ks_rdata);

  assign stat_o.search_go  = search_go;
  assign stat_o.lo_lt_hi   = lo_q < hi_q;
  assign stat_o.bytes_left = i_q < n_q;
  assign stat_o.byte_diff  = qb_rdata != ks_rdata;

  bkls_ram #(.WIDTH(8), .DEPTH(KEY_STORE_BYTES)) u_key_store (
    .clk_i   (clk_i),
    .we_i    (ks_we),
    .waddr_i (wr_pos[AW-1:0]),
    .wdata_i (key_byte_i),
    .raddr_i (ks_rsum[AW-1:0]),
    .rdata_o (ks_rdata)
  );

  // start and length of each boundary key
  bkls_ram #(.WIDTH(TW), .DEPTH(MAX_KEYS)) u_key_table (
    .clk_i   (clk_i),
    .we_i    (add_ok),
    .waddr_i (keys_q[IW-1:0]),
    .wdata_i ({used_q[AW-1:0], len_now}),
    .raddr_i (mid),
    .rdata_o (kt_rdata)
  );

  bkls_ram #(.WIDTH(8), .DEPTH(MAX_KEY_LEN)) u_query_buf (
    .clk_i   (clk_i),
    .we_i    (qb_we),
    .waddr_i (cur_len_q[QW-1:0]),
    .wdata_i (key_byte_i),
    .raddr_i (i_q[QW-1:0]),
    .rdata_o (qb_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q      <= BcWidth'(1);
      off_q     <= '0;
      cur_len_q <= '0;
      ovf_q     <= 1'b0;
      keys_q    <= '0;
      used_q    <= '0;
      valid_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_BOUNDARY_COUNT) begin
          bc_q <= cfg_wdata_i[BcWidth-1:0];
        end else begin
          off_q <= cfg_wdata_i;
        end
      end
      if (cmd_i.take) begin
        if (last_byte_i) begin
          cur_len_q <= '0;
          ovf_q     <= 1'b0;
        end else begin
          cur_len_q <= len_now;
          ovf_q     <= ovf_now;
        end
      end
      if (add_ok) begin
        keys_q <= keys_q + 1'b1;
        used_q <= BW'(SW'(used_q) + SW'(len_now));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    found_q  <= found_d;
    status_q <= status_d;
    if (search_go) begin
      lo_q   <= '0;
      hi_q   <= eff_m1[IW-1:0];
      qlen_q <= len_now;
    end
    if (cmd_i.load_key) begin
      start_q <= rd_start;
      klen_q  <= rd_len;
      n_q     <= (rd_len < qlen_q) ? rd_len : qlen_q;
      i_q     <= '0;
    end
    if (cmd_i.next_byte) begin
      i_q <= i_q + 1'b1;
    end
    if (cmd_i.update_len || cmd_i.update_byte) begin
      if (below) begin
        hi_q <= mid - 1'b1;
      end else begin
        lo_q <= mid;
      end
    end
  end

  always_comb begin
    valid_d  = 1'b0;
    found_d  = '0;
    status_d = ST_OK;
    if (cmd_i.finish) begin
      valid_d = 1'b1;
      found_d = FoundWidth'(lo_q) + FoundWidth'(off_q);
    end else if (is_last && !search_go) begin
      valid_d = 1'b1;
      if (ovf_now) begin
        status_d = ST_TOO_LONG;
      end else if (cmd_field_i == CMD_ADD) begin
        if (tab_full) begin
          status_d = ST_TABLE_FULL;
        end else if (store_full) begin
          status_d = ST_STORE_FULL;
        end else begin
          status_d = ST_OK;
        end
      end else begin
        status_d = ST_INCOMPLETE;
      end
    end
  end

  assign done_o        = valid_q;
  assign found_index_o = found_q;
  assign status_o      = status_q;

endmodule

@@ src/boundary_key_lower_bound_search.sv @@
// channel  direction  ports                                      handshake
// -------  ---------  -----------------------------------------  ------------------------
// input    in         cmd_i, key_byte_i, last_byte_i             start_i & !busy_o
// result   out        found_index_o, status_o                    done_o, one cycle, no stall
// config   in         cfg_idx_i, cfg_wdata_i                     cfg_we_i
//
// a key byte is taken while busy_o is low; only a word marked last gives a result,
// on done_o the cycle after it is taken for an add or an error, and the cycle
// after the closing probe for a search
// a search holds busy_o for about ceil(log2(count)) probes; each probe passes
// the probe and key states, then a fetch and a compare state per byte compared,
// plus a final fetch when all shared bytes match, and a closing probe ends the
// search; the single read port of the key store, one byte a compare, sets this
// reset clears counters, config (count 1, offset 0) and done_o; memories need no clearing
// the receiver cannot stall: every result is shown for exactly one cycle
module boundary_key_lower_bound_search #(
  parameter int MAX_KEYS = 256,
  parameter int KEY_STORE_BYTES = 4096,
  parameter int MAX_KEY_LEN = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input word
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              cmd_i,
  input  logic [7:0]                        key_byte_i,
  input  logic                              last_byte_i,
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [bkls_pkg::CfgDataWidth-1:0] cfg_wdata_i,
  // result word
  output logic                              done_o,
  output logic [bkls_pkg::FoundWidth-1:0]   found_index_o,
  output logic [bkls_pkg::StatusWidth-1:0]  status_o
);

  import bkls_pkg::*;

  bkls_cmd_t  dp_cmd;
  bkls_stat_t dp_stat;

  // sequencer: idle, then probe / key fetch / byte compare loop per midpoint
  bkls_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (dp_stat),
    .cmd_o   (dp_cmd),
    .busy_o  (busy_o)
  );

  // key store, key table, query buffer, counters and search range
  bkls_dp #(
    .MAX_KEYS        (MAX_KEYS),
    .KEY_STORE_BYTES (KEY_STORE_BYTES),
    .MAX_KEY_LEN     (MAX_KEY_LEN)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .stat_o        (dp_stat),
    .cmd_field_i   (cmd_i),
    .key_byte_i    (key_byte_i),
    .last_byte_i   (last_byte_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .done_o        (done_o),
    .found_index_o (found_index_o),
    .status_o      (status_o)
  );

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import bkls_pkg::*;

  localparam int KEYS     = 256;
  localparam int STORE    = 4096;
  localparam int KLEN     = 64;
  localparam int SETTLE   = 16;     // quiet cycles before a register write
  localparam int TAIL     = 150;    // last words go out back to back
  localparam int DRAIN    = 64;
  localparam int WATCHDOG = 10000;  // limit on cycles with no activity

  // dut ports, inputs all known from time zero
  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   start_i     = 1'b0;
  logic                   cmd_i       = CMD_ADD;
  logic [7:0]             key_byte_i  = 8'h00;
  logic                   last_byte_i = 1'b0;
  logic                   cfg_we_i    = 1'b0;
  logic                   cfg_idx_i   = CFG_BOUNDARY_COUNT;
  logic [CfgDataWidth-1:0] cfg_wdata_i = '0;
  logic                   busy_o;
  logic                   done_o;
  logic [FoundWidth-1:0]  found_index_o;
  logic [StatusWidth-1:0] status_o;

  boundary_key_lower_bound_search #(
    .MAX_KEYS(KEYS),
    .KEY_STORE_BYTES(STORE),
    .MAX_KEY_LEN(KLEN)
  ) u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start_i(start_i),
    .busy_o(busy_o),
    .cmd_i(cmd_i),
    .key_byte_i(key_byte_i),
    .last_byte_i(last_byte_i),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .done_o(done_o),
    .found_index_o(found_index_o),
    .status_o(status_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // one lookup or add outcome
  typedef struct packed {
    logic [FoundWidth-1:0]  found;
    logic [StatusWidth-1:0] status;
  } lookup_res_t;

  // one queued word, or a register write
  typedef struct {
    bit          is_reg;
    logic        cmd;
    logic [7:0]  kbyte;
    logic        last;
    logic        ridx;
    logic [31:0] rdata;
  } plan_t;

  plan_t       pending_words[$];
  lookup_res_t owed_results[$];
  int          results_due  = 0;
  int          results_seen = 0;
  int          bad_results  = 0;
  int          settle       = 0;
  int          idle_left    = 0;
  int          quiet        = 0;

  // ---------------------------------------------------------------------------
  // boundary table mirror, fed by accepted words and register writes
  // ---------------------------------------------------------------------------
  logic [7:0] tbl_store [STORE];
  int         tbl_start [KEYS];
  int         tbl_len   [KEYS];
  logic [7:0] qry_buf   [KLEN];
  int         tbl_keys     = 0;
  int         tbl_bytes    = 0;
  int         key_pos      = 0;
  bit         key_overflow = 1'b0;
  logic [8:0] reg_count    = 9'd1;
  logic [31:0] reg_offset  = '0;

  function automatic int live_count();
    return (reg_count > KEYS) ? KEYS : int'(reg_count);
  endfunction

  // query held in qry_buf sorts strictly below boundary k
  function automatic bit query_sorts_below(int qlen, int k);
    int n;
    logic [7:0] a, b;
    n = (qlen < tbl_len[k]) ? qlen : tbl_len[k];
    for (int i = 0; i < n; i++) begin
      a = qry_buf[i];
      b = tbl_store[tbl_start[k] + i];
      if (a != b) return a < b;
    end
    return qlen < tbl_len[k];
  endfunction

  function automatic void write_reg(logic idx, logic [31:0] data);
    if (idx == CFG_BOUNDARY_COUNT) reg_count = data[8:0];
    else reg_offset = data;
  endfunction

  task automatic take_word(logic cmd, logic [7:0] kb, logic last);
    int pos, len, n, lo, hi, mid;
    lookup_res_t r;
    pos = key_pos;
    // bytes past the length limit are dropped and poison the key
    if (pos >= KLEN) key_overflow = 1'b1;
    else begin
      if (cmd == CMD_ADD) begin
        if (tbl_bytes + pos < STORE) tbl_store[tbl_bytes + pos] = kb;
      end else qry_buf[pos] = kb;
      key_pos = pos + 1;
    end
    if (last) begin
      len = key_pos;
      r.found = '0;
      r.status = ST_OK;
      if (key_overflow) r.status = ST_TOO_LONG;
      else if (cmd == CMD_ADD) begin
        if (tbl_keys >= live_count()) r.status = ST_TABLE_FULL;
        else if (tbl_bytes + len > STORE) r.status = ST_STORE_FULL;
        else begin
          tbl_start[tbl_keys] = tbl_bytes;
          tbl_len[tbl_keys] = len;
          tbl_keys++;
          tbl_bytes += len;
        end
      end else begin
        n = live_count();
        if (n == 0 || tbl_keys != n) r.status = ST_INCOMPLETE;
        else begin
          // last boundary not above the query, midpoint rounded up
          lo = 0;
          hi = n - 1;
          while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (query_sorts_below(len, mid)) hi = mid - 1;
            else lo = mid;
          end
          r.found = FoundWidth'(reg_offset) + FoundWidth'(lo);
        end
      end
      key_pos = 0;
      key_overflow = 1'b0;
      owed_results.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus planning, with a light shadow of what the table will hold
  // ---------------------------------------------------------------------------
  int         g_keys  = 0;
  int         g_bytes = 0;
  int         g_eff   = 1;
  logic [7:0] g_store  [STORE];
  bit         g_stored [STORE];
  bit         g_qset   [KLEN];
  logic [7:0] g_key    [KEYS][KLEN];
  int         g_klen   [KEYS];
  logic [7:0] kbuf     [80];

  task automatic plan_reg(logic idx, logic [31:0] data);
    plan_t w;
    w = '{1'b1, CMD_ADD, 8'h00, 1'b0, idx, data};
    pending_words.push_back(w);
    if (idx == CFG_BOUNDARY_COUNT) g_eff = (data[8:0] > KEYS) ? KEYS : int'(data[8:0]);
  endtask

  // sends kbuf[0..len-1]; with mix, some bytes carry the other command,
  // only where the entry they leave behind has been written before
  task automatic plan_key(logic end_cmd, int len, bit mix);
    plan_t w;
    logic c;
    for (int i = 0; i < len; i++) begin
      c = end_cmd;
      if (mix && i < len - 1 && $urandom_range(0, 3) == 0) begin
        if (end_cmd == CMD_SEARCH) begin
          if (i >= KLEN || g_qset[i]) c = CMD_ADD;
        end else if (i >= 1 && (i >= KLEN || g_bytes + i >= STORE ||
                                g_stored[g_bytes + i])) begin
          c = CMD_SEARCH;
        end
      end
      if (i < KLEN) begin
        if (c == CMD_ADD) begin
          if (g_bytes + i < STORE) begin
            g_store[g_bytes + i] = kbuf[i];
            g_stored[g_bytes + i] = 1'b1;
          end
        end else g_qset[i] = 1'b1;
      end
      w = '{1'b0, c, kbuf[i], (i == len - 1), CFG_BOUNDARY_COUNT, 32'h0};
      pending_words.push_back(w);
    end
    if (end_cmd == CMD_ADD && len <= KLEN && g_keys < g_eff && g_bytes + len <= STORE) begin
      for (int i = 0; i < len; i++) g_key[g_keys][i] = g_store[g_bytes + i];
      g_klen[g_keys] = len;
      g_keys++;
      g_bytes += len;
    end
  endtask

  // boundary k leads with byte k, so appended keys stay sorted
  task automatic fill_boundary(int len, bit mix);
    kbuf[0] = g_keys[7:0];
    for (int i = 1; i < len; i++) kbuf[i] = 8'($urandom);
    plan_key(CMD_ADD, len, mix);
  endtask

  // early keys short, later ones sized to leave 2 bytes free at 254 keys
  function automatic int span_len();
    int rem, need, len;
    if (g_keys < 200) return ($urandom_range(0, 15) == 0) ? KLEN : int'($urandom_range(1, 16));
    rem = 254 - g_keys;
    need = 4094 - g_bytes;
    if (rem < 1) return 1;
    len = (need + rem - 1) / rem;
    return (len < 1) ? 1 : ((len > KLEN) ? KLEN : len);
  endfunction

  // query derived from a stored boundary so compares run deep
  task automatic plan_query(bit mix);
    int k, len, p;
    k = $urandom_range(0, g_keys - 1);
    len = g_klen[k];
    for (int i = 0; i < KLEN; i++) kbuf[i] = (i < len) ? g_key[k][i] : 8'($urandom);
    case ($urandom_range(0, 7))
      0: ;                                        // exact boundary
      1: len = $urandom_range(1, len);            // prefix, shorter sorts lower
      2: len = $urandom_range(len, KLEN);         // extended
      3, 4: begin                                 // one byte nudged either way
        p = $urandom_range(0, len - 1);
        kbuf[p] = $urandom_range(0, 1) ? kbuf[p] + 8'd1 : kbuf[p] - 8'd1;
      end
      5: begin
        len = $urandom_range(1, KLEN);
        for (int i = 0; i < len; i++) kbuf[i] = 8'($urandom);
      end
      default: begin                              // all-zero or all-ones
        len = $urandom_range(1, KLEN);
        p = $urandom_range(0, 1);
        for (int i = 0; i < len; i++) kbuf[i] = p ? 8'hFF : 8'h00;
      end
    endcase
    plan_key(CMD_SEARCH, len, mix);
  endtask

  // lookups on the current table, with some adds and overlong keys mixed in
  task automatic query_burst(int n);
    int r;
    for (int q = 0; q < n; q++) begin
      r = $urandom_range(0, 15);
      if (r == 0) fill_boundary($urandom_range(1, 8), 0);
      else if (r == 1) begin
        for (int i = 0; i < 70; i++) kbuf[i] = 8'($urandom);
        plan_key(CMD_SEARCH, $urandom_range(KLEN + 1, 70), 0);
      end else plan_query(r < 5);
    end
  endtask

  task automatic run_phase(int count, logic [31:0] offset, int fill_to, int nq);
    int r, guard;
    plan_reg(CFG_BOUNDARY_COUNT, count);
    plan_reg(CFG_INDEX_OFFSET, offset);
    guard = 0;
    while (g_keys < fill_to && guard < 4000) begin
      guard++;
      r = $urandom_range(0, 15);
      if (r == 0) fill_boundary($urandom_range(KLEN + 1, 70), 0);  // overlong add
      else if (r == 1) plan_query(0);                              // table not complete
      else fill_boundary(span_len(), r < 4);
    end
    query_burst(nq);
  endtask

  // ---------------------------------------------------------------------------
  // driver: one word or one register write at a time from pending_words
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive
    plan_t ent;
    logic  go_start, go_we;
    if (!rst_ni) begin
      start_i  <= 1'b0;
      cfg_we_i <= 1'b0;
    end else begin
      if (cfg_we_i) write_reg(cfg_idx_i, cfg_wdata_i);
      if (start_i && !busy_o) begin
        take_word(cmd_i, key_byte_i, last_byte_i);
        if (last_byte_i) results_due <= results_due + 1;
      end
      // register writes wait for a quiet block with nothing owed
      if (results_due != results_seen || busy_o || start_i || cfg_we_i) settle <= 0;
      else if (settle < SETTLE) settle <= settle + 1;
      if (!(start_i && busy_o)) begin
        go_start = 1'b0;
        go_we = 1'b0;
        if (idle_left != 0) idle_left <= idle_left - 1;
        else if (pending_words.size() != 0) begin
          if (pending_words[0].is_reg) begin
            if (settle >= SETTLE && !cfg_we_i) begin
              ent = pending_words.pop_front();
              go_we = 1'b1;
              cfg_idx_i   <= ent.ridx;
              cfg_wdata_i <= ent.rdata;
            end
          end else begin
            ent = pending_words.pop_front();
            go_start = 1'b1;
            cmd_i       <= ent.cmd;
            key_byte_i  <= ent.kbyte;
            last_byte_i <= ent.last;
            // gap after this word, never in the tail
            if (pending_words.size() > TAIL && $urandom_range(0, 9) == 0)
              idle_left <= $urandom_range(1, 17);
          end
        end
        start_i  <= go_start;
        cfg_we_i <= go_we;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every done word against the oldest owed result
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check
    lookup_res_t want;
    if (rst_ni && done_o) begin
      results_seen <= results_seen + 1;
      if (owed_results.size() == 0) begin
        if (bad_results < 10)
          $display("unexpected result: index %0h status %0d", found_index_o, status_o);
        bad_results++;
      end else begin
        want = owed_results.pop_front();
        if (want.found !== found_index_o || want.status !== status_o) begin
          if (bad_results < 10)
            $display("mismatch: want index %0h status %0d, got index %0h status %0d",
                     want.found, want.status, found_index_o, status_o);
          bad_results++;
        end
      end
    end
  end

  // watchdog on cycles with no word taken, no result and no write
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o || cfg_we_i) quiet <= 0;
    else if (quiet >= WATCHDOG) begin
      $display("boundary_key_lower_bound_search regression: fail");
      $finish;
    end else quiet <= quiet + 1;
  end

  initial begin : run
    // directed: count 1, offset 0 out of reset
    kbuf[0] = 8'h00;
    plan_key(CMD_SEARCH, 1, 0);               // nothing stored yet
    kbuf[0] = 8'h00; kbuf[1] = 8'hFF;
    plan_key(CMD_ADD, 2, 0);                  // boundary 0
    kbuf[0] = 8'h01;
    plan_key(CMD_ADD, 1, 0);                  // table already full
    kbuf[0] = 8'h00;
    plan_key(CMD_SEARCH, 1, 0);
    for (int i = 0; i < 70; i++) kbuf[i] = 8'hFF;
    plan_key(CMD_SEARCH, KLEN, 0);            // longest legal query
    plan_key(CMD_SEARCH, KLEN + 2, 0);        // overlong query
    plan_key(CMD_ADD, KLEN + 1, 0);           // overlong wins over full table
    // zero count: adds refused, searches incomplete
    plan_reg(CFG_BOUNDARY_COUNT, 0);
    kbuf[0] = 8'h02;
    plan_key(CMD_ADD, 1, 0);
    plan_key(CMD_SEARCH, 1, 0);
    // two boundaries with the largest offset, index carries into bit 32
    plan_reg(CFG_BOUNDARY_COUNT, 2);
    plan_reg(CFG_INDEX_OFFSET, 32'hFFFF_FFFF);
    plan_key(CMD_SEARCH, 1, 0);
    kbuf[0] = 8'h01; kbuf[1] = 8'h00;
    plan_key(CMD_ADD, 2, 0);                  // boundary 1
    plan_key(CMD_SEARCH, 2, 0);               // equal to boundary 1
    plan_key(CMD_SEARCH, 1, 0);               // prefix of boundary 1
    kbuf[0] = 8'h00; kbuf[1] = 8'hFF; kbuf[2] = 8'h00;
    plan_key(CMD_SEARCH, 3, 0);               // boundary 0 extended
    kbuf[0] = 8'hFF;
    plan_key(CMD_SEARCH, 1, 0);               // above everything
    // count lowered under the stored keys
    plan_reg(CFG_BOUNDARY_COUNT, 1);
    plan_key(CMD_SEARCH, 1, 0);

    // random phases, table only grows
    run_phase(5, 32'h0, 5, 5);
    run_phase(9, $urandom, 9, 5);
    // count above the key limit is clamped, table stays incomplete
    run_phase(511, $urandom, 0, 2);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_words.size() != 0 || start_i || cfg_we_i || owed_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (bad_results == 0 && owed_results.size() == 0)
      $display("boundary_key_lower_bound_search regression: pass");
    else
      $display("boundary_key_lower_bound_search regression: fail");
    $finish;
  end

endmodule
